// ===== hdl/bfp_pkg.sv =====
// Shared constants, codes and controller/datapath types for the byte FIFO pool.
package bfp_pkg;

    // Pool geometry
    localparam int POOL_SIZE   = 8;
    localparam int QUEUE_DEPTH = 16;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int ID_W    = 3;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    // Derived widths and limits
    localparam int SLOT_W      = $clog2(POOL_SIZE);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(POOL_SIZE * QUEUE_DEPTH);
    localparam int FILL_MAX    = (1 << FILL_W) - 1;
    localparam int ID_SPAN     = 1 << ID_W;
    localparam int GRANT_LIMIT = (POOL_SIZE < ID_SPAN) ? POOL_SIZE : ID_SPAN;

    // Stream packing
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_USED_W   = DATA_W + ID_W + FILL_W + 1;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;
    localparam int IN_PAD_W     = IN_TDATA_W - ID_W - DATA_W;
    localparam int OUT_GRANT_LO = DATA_W;
    localparam int OUT_FILL_LO  = DATA_W + ID_W;
    localparam int OUT_FULL_BIT = DATA_W + ID_W + FILL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NO_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_EXEC   = 2'd1,
        FSM_RESULT = 2'd2
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming item
        logic exec;        // apply the item to the pool state
        logic load_out;    // move a result into the output register
        logic from_stage;  // result comes from the staging registers
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_read;    // item is a good pop, data comes from the registered store read
        logic out_free;    // output register can take a result this cycle
    } dp_stat_t;

    // Ring pointer advance with wrap
    function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) + 1 >= QUEUE_DEPTH)
        begin
            r = '0;
        end
        else
        begin
            r = PTR_W'(p + 1'b1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/bfp_ctrl.sv =====
// Sequencing state machine for the byte FIFO pool.
module bfp_ctrl
    import bfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output ctrl_cmd_t  ctrl_cmd,
    input  dp_stat_t   dp_stat
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctrl_cmd   = '0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                s_tready         = 1'b1;
                ctrl_cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                ctrl_cmd.exec = 1'b1;
                // a good pop goes on to the result state to wait for the store read
                if (dp_stat.pop_read)
                begin
                    state_next = FSM_RESULT;
                end
                else if (dp_stat.out_free)
                begin
                    ctrl_cmd.load_out = 1'b1;
                    state_next        = FSM_IDLE;
                end
                else
                begin
                    state_next = FSM_RESULT;
                end
            end
            FSM_RESULT:
            begin
                ctrl_cmd.from_stage = 1'b1;
                if (dp_stat.out_free)
                begin
                    ctrl_cmd.load_out = 1'b1;
                    state_next        = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bfp_dpath.sv =====
// Pool state, byte store, allocator and result registers for the byte FIFO pool.
module bfp_dpath
    import bfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              ctrl_cmd,
    output dp_stat_t               dp_stat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]      m_tuser
);

    // Captured item
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] din_reg;

    // Per-buffer state
    logic [PTR_W-1:0] head_reg   [POOL_SIZE];
    logic [PTR_W-1:0] tail_reg   [POOL_SIZE];
    logic [CNT_W-1:0] count_reg  [POOL_SIZE];
    logic [POOL_SIZE-1:0] in_use_reg;

    // Byte store
    logic [DATA_W-1:0] mem [POOL_SIZE * QUEUE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Staged result
    logic [ID_W-1:0]   res_grant_reg;
    status_t           res_status_reg;
    logic [FILL_W-1:0] res_fill_reg;
    logic              res_full_reg;
    logic              res_pop_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic [STAT_W-1:0]      out_tuser_reg;

    // Execute-stage signals
    logic              grant_found;
    logic [SLOT_W-1:0] grant_idx;
    logic              id_ok;
    logic [SLOT_W-1:0] who;
    logic [CNT_W-1:0]  cnt;
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic              push_ok;
    logic              pop_ok;
    logic              req_ok;
    logic              rel_ok;
    logic              report;
    logic [CNT_W-1:0]  new_cnt;
    status_t           status;
    logic [FILL_W-1:0] fill;
    logic              full;
    logic [ID_W-1:0]   grant_out;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Result selected for the output register
    logic [DATA_W-1:0] sel_data;
    logic [ID_W-1:0]   sel_grant;
    status_t           sel_status;
    logic [FILL_W-1:0] sel_fill;
    logic              sel_full;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            cmd_reg <= cmd_t'(s_tuser);
            id_reg  <= s_tdata[ID_W-1:0];
            din_reg <= s_tdata[ID_W +: DATA_W];
        end
    end

    // Lowest free buffer that an id can name
    always_comb
    begin
        grant_found = 1'b0;
        grant_idx   = '0;
        for (int i = GRANT_LIMIT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                grant_found = 1'b1;
                grant_idx   = SLOT_W'(i);
            end
        end
    end

    // Addressed buffer and its state
    assign id_ok = (32'(id_reg) < POOL_SIZE);
    assign who   = (cmd_reg == CMD_REQUEST) ? grant_idx : SLOT_W'(id_reg);
    assign cnt   = count_reg[who];
    assign head  = head_reg[who];
    assign tail  = tail_reg[who];

    // Command decode and outcome
    always_comb
    begin
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        req_ok  = 1'b0;
        rel_ok  = 1'b0;
        report  = 1'b0;
        new_cnt = cnt;
        status  = ST_OK;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                if (!id_ok)
                begin
                    status = ST_DROPPED;
                end
                else if (32'(cnt) >= QUEUE_DEPTH)
                begin
                    status = ST_DROPPED;
                    report = 1'b1;
                end
                else
                begin
                    push_ok = 1'b1;
                    report  = 1'b1;
                    new_cnt = CNT_W'(cnt + 1'b1);
                end
            end
            CMD_POP:
            begin
                if (!id_ok)
                begin
                    status = ST_EMPTY;
                end
                else if (cnt == '0)
                begin
                    status = ST_EMPTY;
                    report = 1'b1;
                end
                else
                begin
                    pop_ok  = 1'b1;
                    report  = 1'b1;
                    new_cnt = CNT_W'(cnt - 1'b1);
                end
            end
            CMD_REQUEST:
            begin
                if (grant_found)
                begin
                    req_ok = 1'b1;
                    report = 1'b1;
                end
                else
                begin
                    status = ST_NO_FREE;
                end
            end
            CMD_RELEASE:
            begin
                if (id_ok)
                begin
                    rel_ok  = 1'b1;
                    report  = 1'b1;
                    new_cnt = '0;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Fill level saturates at the field maximum
    always_comb
    begin
        fill = '0;
        full = 1'b0;
        if (report)
        begin
            fill = (32'(new_cnt) > FILL_MAX) ? FILL_W'(FILL_MAX) : FILL_W'(new_cnt);
            full = (32'(new_cnt) >= QUEUE_DEPTH);
        end
    end

    assign grant_out = req_ok ? ID_W'(grant_idx) : '0;
    assign wr_addr   = ADDR_W'(ADDR_W'(who) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head));
    assign rd_addr   = ADDR_W'(ADDR_W'(who) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail));

    // Per-buffer pointers, counts and allocation map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            in_use_reg <= '0;
        end
        else if (ctrl_cmd.exec)
        begin
            if (push_ok)
            begin
                head_reg[who]  <= next_index(head);
                count_reg[who] <= new_cnt;
            end
            if (pop_ok)
            begin
                tail_reg[who]  <= next_index(tail);
                count_reg[who] <= new_cnt;
            end
            if (req_ok)
            begin
                in_use_reg[who] <= 1'b1;
            end
            if (rel_ok)
            begin
                in_use_reg[who] <= 1'b0;
                head_reg[who]   <= '0;
                tail_reg[who]   <= '0;
                count_reg[who]  <= '0;
            end
        end
    end

    // Byte store with registered read
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.exec && push_ok)
        begin
            mem[wr_addr] <= din_reg;
        end
        if (ctrl_cmd.exec && pop_ok)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result staging
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.exec)
        begin
            res_grant_reg  <= grant_out;
            res_status_reg <= status;
            res_fill_reg   <= fill;
            res_full_reg   <= full;
            res_pop_reg    <= pop_ok;
        end
    end

    // Result source: direct from execute, or from staging
    always_comb
    begin
        if (ctrl_cmd.from_stage)
        begin
            sel_data   = res_pop_reg ? rd_data_reg : '0;
            sel_grant  = res_grant_reg;
            sel_status = res_status_reg;
            sel_fill   = res_fill_reg;
            sel_full   = res_full_reg;
        end
        else
        begin
            sel_data   = '0;
            sel_grant  = grant_out;
            sel_status = status;
            sel_fill   = fill;
            sel_full   = full;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl_cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load_out)
        begin
            out_tdata_reg <= {{OUT_PAD_W{1'b0}}, sel_full, sel_fill, sel_grant, sel_data};
            out_tuser_reg <= sel_status;
        end
    end

    assign dp_stat.pop_read = pop_ok;
    assign dp_stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    // The addressed buffer never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.exec |-> 32'(count_reg[who]) <= QUEUE_DEPTH)
        else $error("buffer count beyond depth");

    // A good pop stages an ok status and a pending byte
    a_pop_staged: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.exec && pop_ok |=> res_pop_reg && res_status_reg == ST_OK)
        else $error("pop result not staged as ok");

    // A full buffer never reports an empty level or a failed request
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_tdata_reg[OUT_FULL_BIT]
            |-> out_tdata_reg[OUT_FILL_LO +: FILL_W] != '0 && out_tuser_reg != ST_NO_FREE)
        else $error("full flag without a fill level");

    // A push into a buffer with room grows it by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.exec && push_ok |=> count_reg[$past(who)] == CNT_W'($past(cnt) + 1'b1))
        else $error("push did not advance count");

endmodule

// ===== hdl/byte_fifo_pool_with_allocator.sv =====
// Top level of the byte FIFO pool: controller and datapath.
//
// A pool of 8 byte ring buffers, 16 bytes each, with an allocation map. Each input item
// carries a command in s_tuser: push, pop, request a free buffer, or release a buffer. Every
// item gives exactly one result item. One item is handled at a time: push, request and
// release pass through capture, then execute, before the result is loaded, and a pop that
// returns a byte also passes the result state for the registered read of the byte store. An
// output register holds the result, so the next item is taken while a result waits; when the
// consumer stalls, a finished result waits in staging and the next item is held off.
// No clearing pass after reset: the byte store is only read where a push wrote.
module byte_fifo_pool_with_allocator
    import bfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // buffer_id[2:0], data_in[10:3], zero pad
    input  logic [CMD_W-1:0]       s_tuser,   // command[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // data_out[7:0], granted_id[10:8],
                                              // fill_level[15:11], is_full[16], zero pad
    output logic [STAT_W-1:0]      m_tuser    // status[1:0]
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    // Sequencer
    bfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctrl_cmd (ctrl_cmd),
        .dp_stat  (dp_stat)
    );

    // Pool state and result path
    bfp_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_cmd (ctrl_cmd),
        .dp_stat  (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/pool_result_checker.sv =====
// Checker for the byte FIFO pool: predicts every result item and compares it with the DUT.
module pool_result_checker
    import bfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // buffer_id[2:0], data_in[10:3], zero pad
    input  logic [CMD_W-1:0]       s_tuser,   // command[1:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // data_out[7:0], granted_id[10:8],
                                              // fill_level[15:11], is_full[16], zero pad
    input  logic [STAT_W-1:0]      m_tuser,   // status[1:0]
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [ID_W-1:0]   granted_id;
        status_t           status;
        logic [FILL_W-1:0] fill_level;
        logic              is_full;
    } pool_result_t;

    // Shadow copy of the pool
    logic [DATA_W-1:0] ring_bytes [POOL_SIZE][QUEUE_DEPTH];
    int unsigned       wr_idx     [POOL_SIZE];
    int unsigned       rd_idx     [POOL_SIZE];
    int unsigned       held       [POOL_SIZE];
    bit                allocated  [POOL_SIZE];

    pool_result_t expected_results[$];
    pool_result_t want;
    pool_result_t got;
    pool_result_t fresh;
    int           errors = 0;
    int           outstanding = 0;

    assign fail_count = errors;
    assign pending    = outstanding;

    function automatic int unsigned ring_advance(input int unsigned p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    // Apply one command to the shadow pool and work out its result item
    task automatic apply_command(input cmd_t cmd, input int unsigned id,
                                 input logic [DATA_W-1:0] din, output pool_result_t res);
        bit          report;
        bit          found;
        int unsigned who;
        int unsigned c;
        res    = '0;
        report = 1'b0;
        found  = 1'b0;
        who    = 0;
        if (cmd == CMD_REQUEST)
        begin
            res.status = ST_NO_FREE;
            for (int i = 0; i < GRANT_LIMIT; i++)
            begin
                if (!found && !allocated[i])
                begin
                    found          = 1'b1;
                    allocated[i]   = 1'b1;
                    res.granted_id = ID_W'(i);
                    res.status     = ST_OK;
                    report         = 1'b1;
                    who            = i;
                end
            end
        end
        else if (id >= POOL_SIZE)
        begin
            // no such buffer
            if (cmd == CMD_PUSH)
            begin
                res.status = ST_DROPPED;
            end
            else if (cmd == CMD_POP)
            begin
                res.status = ST_EMPTY;
            end
        end
        else
        begin
            report = 1'b1;
            who    = id;
            case (cmd)
                CMD_PUSH:
                begin
                    if (held[id] >= QUEUE_DEPTH)
                    begin
                        res.status = ST_DROPPED;
                    end
                    else
                    begin
                        ring_bytes[id][wr_idx[id]] = din;
                        wr_idx[id] = ring_advance(wr_idx[id]);
                        held[id]++;
                    end
                end
                CMD_POP:
                begin
                    if (held[id] == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.data_out = ring_bytes[id][rd_idx[id]];
                        rd_idx[id] = ring_advance(rd_idx[id]);
                        held[id]--;
                    end
                end
                default:
                begin
                    // release frees and empties the buffer
                    allocated[id] = 1'b0;
                    wr_idx[id]    = 0;
                    rd_idx[id]    = 0;
                    held[id]      = 0;
                end
            endcase
        end
        if (report)
        begin
            c              = held[who];
            res.fill_level = FILL_W'((c > FILL_MAX) ? FILL_MAX : c);
            res.is_full    = (c >= QUEUE_DEPTH);
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                wr_idx[i]    = 0;
                rd_idx[i]    = 0;
                held[i]      = 0;
                allocated[i] = 1'b0;
            end
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.data_out   = m_tdata[DATA_W-1:0];
                got.granted_id = m_tdata[OUT_GRANT_LO +: ID_W];
                got.fill_level = m_tdata[OUT_FILL_LO +: FILL_W];
                got.is_full    = m_tdata[OUT_FULL_BIT];
                got.status     = status_t'(m_tuser);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result item with nothing expected, tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_out", int'(want.data_out), int'(got.data_out));
                    check_field("granted_id", int'(want.granted_id), int'(got.granted_id));
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("fill_level", int'(want.fill_level), int'(got.fill_level));
                    check_field("is_full", int'(want.is_full), int'(got.is_full));
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_command(cmd_t'(s_tuser), int'(s_tdata[ID_W-1:0]),
                              s_tdata[ID_W +: DATA_W], fresh);
                expected_results.push_back(fresh);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the byte FIFO pool: clock, reset, stimulus and verdict.
module tb;
    import bfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PCT    = 32;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int issued      = 0;
    bit quiet       = 1'b0;   // no idling on either side
    bit hold_req    = 1'b0;   // receiver holds off for a long stretch

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_fifo_pool_with_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pool_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one item, with random idle cycles ahead of it unless quiet; returns at the falling edge
    task automatic send_item(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [DATA_W-1:0] din);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {IN_PAD_W'(0), din, id};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        issued++;
    endtask

    // Stop sending until every expected result item has come back
    task automatic drain;
        s_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // In half the rounds push bursts followed by pops on one buffer, plus allocation traffic and noise
    task automatic random_sequences(input int count);
        int stop;
        int b;
        int k;
        int j;
        int r;
        stop = issued + count;
        while (issued < stop)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                b = $urandom_range(0, POOL_SIZE - 1);
                k = $urandom_range(1, QUEUE_DEPTH + 2);
                repeat (k) send_item(CMD_PUSH, ID_W'(b), DATA_W'($urandom_range(0, 255)));
                j = $urandom_range(0, k + 2);
                repeat (j) send_item(CMD_POP, ID_W'(b), DATA_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(CMD_RELEASE, ID_W'(b), DATA_W'($urandom_range(0, 255)));
                end
            end
            else if (r < 7)
            begin
                send_item(CMD_REQUEST, ID_W'($urandom_range(0, 7)),
                          DATA_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(CMD_RELEASE, ID_W'($urandom_range(0, 7)),
                              DATA_W'($urandom_range(0, 255)));
                end
            end
            else
            begin
                send_item(cmd_t'(CMD_W'($urandom_range(0, 3))), ID_W'($urandom_range(0, 7)),
                          DATA_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: random back-pressure, or a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pop on empty, extreme bytes, release of a non-empty buffer
        send_item(CMD_POP, 3'd0, 8'h00);
        send_item(CMD_PUSH, 3'd0, 8'h00);
        send_item(CMD_PUSH, 3'd0, 8'hFF);
        send_item(CMD_PUSH, 3'd7, 8'hA5);
        send_item(CMD_PUSH, 3'd7, 8'h5A);
        send_item(CMD_POP, 3'd0, 8'hFF);
        send_item(CMD_POP, 3'd0, 8'h00);
        send_item(CMD_POP, 3'd7, 8'h00);
        send_item(CMD_RELEASE, 3'd7, 8'h00);
        send_item(CMD_POP, 3'd7, 8'h00);
        // Grant every buffer, then one request with none free
        repeat (POOL_SIZE) send_item(CMD_REQUEST, 3'd0, 8'h00);
        send_item(CMD_REQUEST, 3'd7, 8'hFF);
        send_item(CMD_RELEASE, 3'd3, 8'h00);
        send_item(CMD_REQUEST, 3'd0, 8'h00);
        send_item(CMD_RELEASE, 3'd0, 8'h00);
        send_item(CMD_RELEASE, 3'd5, 8'h00);
        drain;

        // Receiver holds off while the sender overfills one buffer
        hold_req = 1'b1;
        repeat (QUEUE_DEPTH + 4) send_item(CMD_PUSH, 3'd2, DATA_W'($urandom_range(0, 255)));
        repeat (QUEUE_DEPTH + 2) send_item(CMD_POP, 3'd2, DATA_W'($urandom_range(0, 255)));
        drain;

        random_sequences(270);
        quiet = 1'b1;
        random_sequences(130);
        quiet = 1'b0;
        random_sequences(270);

        drain;
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
